@@ hw/rtl/crc_pkg.sv @@
`timescale 1ns / 1ps

package crc_pkg;

   // Command codes carried on req_tuser
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_RADIUS = 2'd1;
   localparam logic [1:0] STATUS_BAD_KIND   = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE    = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_WIDTH      = 2'd0;
   localparam logic [1:0] REG_HEIGHT     = 2'd1;
   localparam logic [1:0] REG_BACKGROUND = 2'd2;

   // Shape kinds
   localparam logic [7:0] KIND_FILLED  = 8'h43;
   localparam logic [7:0] KIND_OUTLINE = 8'h63;

   // Field widths
   localparam int COORD_W = 19;
   localparam int BYTE_W  = 8;
   localparam int SIZE_W  = 9;

   // Shared multiplier operand and product widths (radius less one fits 20 bits)
   localparam int OP_W   = 20;
   localparam int PROD_W = 2 * OP_W;

   // Request tdata layout, lowest bit first
   localparam int CX_LSB   = 0;
   localparam int CY_LSB   = 19;
   localparam int RAD_LSB  = 38;
   localparam int KIND_LSB = 57;
   localparam int INK_LSB  = 65;
   localparam int COL_LSB  = 73;
   localparam int ROW_LSB  = 81;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_READ  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

endpackage

@@ hw/rtl/circle_raster_canvas.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Handshake                 | Payload
// req     | in  | req_tvalid / req_tready   | req_tuser cmd, req_tdata circle and read fields
// rsp     | out | rsp_tvalid / rsp_tready   | rsp_tdata pixel, status
// csr     | in  | csr_write_en              | csr_index, csr_wdata
//
// Clear writes the background across width*height pixels, one pixel written per cycle.
// Draw squares the centre, radius and radius less one on the shared 20x20 multiplier,
// then tests width*height pixels through the incremental distance adder.
// Read goes through the registered canvas read port.
// Reset initialises control and configuration only; the canvas holds garbage until a clear.
// req_tready is low from an accepted transfer until its result transfer completes.
module circle_raster_canvas
   import crc_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cx[18:0], cy[37:19], radius[56:38], shape_kind[64:57], ink[72:65],
   // read_col[80:73], read_row[88:81], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel[7:0], status[9:8], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   localparam int CLW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RLW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int IDXW = (CLW > RLW) ? CLW : RLW;
   localparam int CNTW = ((IDXW > SIZE_W) ? IDXW : SIZE_W) + 2;
   localparam int CW   = ((IDXW + FRAC_BITS > COORD_W - 1) ? IDXW + FRAC_BITS : COORD_W - 1) + 3;
   localparam int DW   = 2 * CW;

   localparam logic signed [CW-1:0]   ONE_C  = CW'(64'd1 << FRAC_BITS);
   localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(64'd1 << FRAC_BITS);
   localparam logic signed [DW-1:0]   ONE2_D = DW'(64'd1 << (2 * FRAC_BITS));
   localparam logic [CNTW-1:0]        MAX_W_C = CNTW'(MAX_WIDTH);
   localparam logic [CNTW-1:0]        MAX_H_C = CNTW'(MAX_HEIGHT);

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] cfg_w_ff, cfg_w_in;
   logic [SIZE_W-1:0] cfg_h_ff, cfg_h_in;
   logic [BYTE_W-1:0] cfg_bg_ff, cfg_bg_in;

   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [COORD_W-1:0] r_ff, r_in;
   logic                      fill_ff, fill_in;
   logic                      rin_neg_ff, rin_neg_in;
   logic [BYTE_W-1:0]         ink_ff, ink_in;
   logic [2:0]                step_ff, step_in;

   logic signed [OP_W-1:0]   mul_op;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [CW-1:0] dx_ff, dx_in;
   logic signed [CW-1:0] dy_ff, dy_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [DW-1:0] drow_ff, drow_in;
   logic signed [DW-1:0] r2_ff, r2_in;
   logic signed [DW-1:0] rin2_ff, rin2_in;

   logic [CLW-1:0] x_ff, x_in;
   logic [RLW-1:0] y_ff, y_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [BYTE_W-1:0] canvas_mem [MAX_HEIGHT][MAX_WIDTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [CLW-1:0]    rd_col;
   logic [RLW-1:0]    rd_row;

   logic [CNTW-1:0] w_eff, h_eff;
   logic            last_col, last_row;
   logic            in_circle, edge_hit, paint;
   logic signed [DW-1:0] col_step, row_step;
   logic signed [CW-1:0] neg_cx, neg_cy;

   // Request fields
   logic [1:0]                req_cmd;
   logic signed [COORD_W-1:0] req_cx, req_cy, req_r;
   logic [BYTE_W-1:0]         req_kind, req_ink, req_col, req_row;

   assign req_cmd  = req_tuser;
   assign req_cx   = req_tdata[CX_LSB +: COORD_W];
   assign req_cy   = req_tdata[CY_LSB +: COORD_W];
   assign req_r    = req_tdata[RAD_LSB +: COORD_W];
   assign req_kind = req_tdata[KIND_LSB +: BYTE_W];
   assign req_ink  = req_tdata[INK_LSB +: BYTE_W];
   assign req_col  = req_tdata[COL_LSB +: BYTE_W];
   assign req_row  = req_tdata[ROW_LSB +: BYTE_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BYTE_W - 2){1'b0}}, rsp_status_ff, rsp_pixel_ff};

   // Clamp the configured size to the canvas store
   assign w_eff = (CNTW'(cfg_w_ff) > MAX_W_C) ? MAX_W_C : CNTW'(cfg_w_ff);
   assign h_eff = (CNTW'(cfg_h_ff) > MAX_H_C) ? MAX_H_C : CNTW'(cfg_h_ff);

   assign last_col = (CNTW'(x_ff) + CNTW'(1)) == w_eff;
   assign last_row = (CNTW'(y_ff) + CNTW'(1)) == h_eff;

   // Squared distance steps: (d+1)^2 = d^2 + 2d + 1 in fixed point
   assign col_step = d_ff + (DW'(dx_ff) <<< (FRAC_BITS + 1)) + ONE2_D;
   assign row_step = drow_ff + (DW'(dy_ff) <<< (FRAC_BITS + 1)) + ONE2_D;
   assign neg_cx   = -CW'(cx_ff);
   assign neg_cy   = -CW'(cy_ff);

   // Pixel coverage against the squared radii
   assign in_circle = (d_ff <= r2_ff);
   assign edge_hit  = in_circle && (rin_neg_ff || (d_ff > rin2_ff));
   assign paint     = (in_circle && fill_ff) || edge_hit;

   // Shared multiplier operand: centre x, centre y, radius, radius less one
   always_comb begin
      case (step_ff)
         3'd0:    mul_op = OP_W'(cx_ff);
         3'd1:    mul_op = OP_W'(cy_ff);
         3'd2:    mul_op = OP_W'(r_ff);
         3'd3:    mul_op = OP_W'(r_ff) - ONE_OP;
         default: mul_op = '0;
      endcase
   end

   assign prod_in = PROD_W'(mul_op) * PROD_W'(mul_op);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cfg_w_in      = cfg_w_ff;
      cfg_h_in      = cfg_h_ff;
      cfg_bg_in     = cfg_bg_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      r_in          = r_ff;
      fill_in       = fill_ff;
      rin_neg_in    = rin_neg_ff;
      ink_in        = ink_ff;
      step_in       = step_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      d_in          = d_ff;
      drow_in       = drow_ff;
      r2_in         = r2_ff;
      rin2_in       = rin2_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_data       = ink_ff;
      rd_en         = 1'b0;
      rd_col        = CLW'(req_col);
      rd_row        = RLW'(req_row);

      // Configuration writes
      if (csr_write_en) begin
         case (csr_index)
            REG_WIDTH:      cfg_w_in  = csr_wdata;
            REG_HEIGHT:     cfg_h_in  = csr_wdata;
            REG_BACKGROUND: cfg_bg_in = csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rsp_pixel_in  = '0;
               rsp_status_in = STATUS_OK;
               x_in          = '0;
               y_in          = '0;
               state_in      = ST_RESP;
               rsp_valid_in  = 1'b1;
               case (req_cmd)
                  CMD_CLEAR: begin
                     if (w_eff != '0 && h_eff != '0) begin
                        state_in     = ST_CLEAR;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  CMD_DRAW: begin
                     if (req_r <= 0) begin
                        rsp_status_in = STATUS_BAD_RADIUS;
                     end else if (!(req_kind inside {KIND_FILLED, KIND_OUTLINE})) begin
                        rsp_status_in = STATUS_BAD_KIND;
                     end else if (w_eff != '0 && h_eff != '0) begin
                        cx_in        = req_cx;
                        cy_in        = req_cy;
                        r_in         = req_r;
                        fill_in      = (req_kind == KIND_FILLED);
                        rin_neg_in   = (OP_W'(req_r) < ONE_OP);
                        ink_in       = req_ink;
                        step_in      = '0;
                        state_in     = ST_SETUP;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     if (CNTW'(req_col) < w_eff && CNTW'(req_row) < h_eff) begin
                        rd_en        = 1'b1;
                        state_in     = ST_READ;
                        rsp_valid_in = 1'b0;
                     end else begin
                        rsp_status_in = STATUS_OUTSIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Write the background byte across the canvas in use
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = cfg_bg_ff;
            if (last_col) begin
               x_in = '0;
               if (last_row) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  y_in = y_ff + RLW'(1);
               end
            end else begin
               x_in = x_ff + CLW'(1);
            end
         end

         // Square centre and radii, one product a cycle, each stored from the product register in the cycle after
         ST_SETUP: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: drow_in = DW'(prod_ff);
               3'd2: drow_in = drow_ff + DW'(prod_ff);
               3'd3: r2_in   = DW'(prod_ff);
               3'd4: begin
                  rin2_in  = DW'(prod_ff);
                  d_in     = drow_ff;
                  dx_in    = neg_cx;
                  dy_in    = neg_cy;
                  state_in = ST_SCAN;
               end
               default: ;
            endcase
         end

         // Test one pixel a cycle and advance the squared distance
         ST_SCAN: begin
            wr_en = paint;
            if (last_col) begin
               x_in = '0;
               if (last_row) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  y_in    = y_ff + RLW'(1);
                  dy_in   = dy_ff + ONE_C;
                  drow_in = row_step;
                  d_in    = row_step;
                  dx_in   = neg_cx;
               end
            end else begin
               x_in  = x_ff + CLW'(1);
               dx_in = dx_ff + ONE_C;
               d_in  = col_step;
            end
         end

         ST_READ: begin
            rsp_pixel_in = rd_data_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end

         // Hold the result until its transfer
         ST_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_w_ff     <= SIZE_W'(256);
         cfg_h_ff     <= SIZE_W'(256);
         cfg_bg_ff    <= BYTE_W'(32);
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         cfg_bg_ff    <= cfg_bg_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      r_ff          <= r_in;
      fill_ff       <= fill_in;
      rin_neg_ff    <= rin_neg_in;
      ink_ff        <= ink_in;
      prod_ff       <= prod_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      d_ff          <= d_in;
      drow_ff       <= drow_in;
      r2_ff         <= r2_in;
      rin2_ff       <= rin2_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Canvas store: one write port at the scan position, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         canvas_mem[y_ff][x_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= canvas_mem[rd_row][rd_col];
      end
   end

endmodule

@@ dv/circle_raster_canvas_test.sv @@
`timescale 1ns / 1ps

module circle_raster_canvas_test;
   import crc_pkg::*;

   localparam int CANVAS_MAX     = 256;
   localparam int ONE            = 256;      // one pixel in Q.8 fixed point
   localparam int FROM_MODEL     = -1;       // reply taken from the predictor
   localparam int WATCHDOG_LIMIT = 300000;
   localparam logic [1:0] CMD_NONE   = 2'd3;  // unused command code
   localparam logic [1:0] REG_UNUSED = 2'd3;  // index past the last register

   typedef struct {
      logic [1:0]         cmd;
      logic signed [18:0] cx;
      logic signed [18:0] cy;
      logic signed [18:0] rad;
      logic [7:0]         kind;
      logic [7:0]         ink;
      logic [7:0]         col;
      logic [7:0]         row;
   } canvas_cmd_type;

   typedef struct {
      logic [7:0] pixel;
      logic [1:0] status;
   } pixel_reply_type;

   typedef struct {
      bit             csr;
      logic [1:0]     csr_idx;
      logic [8:0]     csr_val;
      canvas_cmd_type req;
      int             pixel;
      int             status;
   } plan_row_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata    = '0;
   logic [1:0]            req_tuser    = CMD_CLEAR;
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_write_en = 1'b0;
   logic [1:0]            csr_index    = REG_WIDTH;
   logic [SIZE_W-1:0]     csr_wdata    = '0;

   // shadow of the canvas and its registers
   logic [7:0]   canvas_img [0:CANVAS_MAX-1][0:CANVAS_MAX-1];
   logic [8:0]   width_reg  = 9'd256;
   logic [8:0]   height_reg = 9'd256;
   logic [7:0]   bg_reg     = 8'd32;

   pixel_reply_type expected_q [$];
   plan_row_type    plan_q [$];
   pixel_reply_type got_reply;
   int              errors       = 0;
   int              quiet_cycles = 0;
   int              idle_pct     = 30;
   bit              calm         = 1'b0;
   int              hold_cycles  = 0;
   int              n_clear = 0, n_draw = 0, n_read = 0, n_none = 0;
   int              n_rejected = 0, n_outside = 0, n_checked = 0, n_reg_writes = 0;

   circle_raster_canvas u_top (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clamp_size(logic [8:0] v);
      return (v > CANVAS_MAX) ? CANVAS_MAX : int'(v);
   endfunction

   // Advance the shadow canvas by one command and return its reply
   function automatic pixel_reply_type canvas_reply(canvas_cmd_type c);
      pixel_reply_type res;
      int              cols, rows;
      longint          cx, cy, r, r2, rin, rin2, dx, dy, d;
      bit              covered, on_rim;
      res.pixel  = 8'h00;
      res.status = STATUS_OK;
      cols = clamp_size(width_reg);
      rows = clamp_size(height_reg);
      case (c.cmd)
         CMD_CLEAR: begin
            for (int y = 0; y < rows; y++)
               for (int x = 0; x < cols; x++)
                  canvas_img[8'(y)][8'(x)] = bg_reg;
         end
         CMD_DRAW: begin
            cx = longint'(c.cx);
            cy = longint'(c.cy);
            r  = longint'(c.rad);
            if (r <= 0) begin
               res.status = STATUS_BAD_RADIUS;
            end else if (!(c.kind inside {KIND_FILLED, KIND_OUTLINE})) begin
               res.status = STATUS_BAD_KIND;
            end else begin
               r2   = r * r;
               rin  = r - ONE;
               rin2 = rin * rin;
               for (int y = 0; y < rows; y++) begin
                  dy = longint'(y) * ONE - cy;
                  for (int x = 0; x < cols; x++) begin
                     dx      = longint'(x) * ONE - cx;
                     d       = dx * dx + dy * dy;
                     covered = (d <= r2);
                     on_rim  = covered && (rin < 0 || d > rin2);
                     if ((covered && c.kind == KIND_FILLED) || on_rim)
                        canvas_img[8'(y)][8'(x)] = c.ink;
                  end
               end
            end
         end
         CMD_READ: begin
            if (int'(c.col) < cols && int'(c.row) < rows)
               res.pixel = canvas_img[c.row][c.col];
            else
               res.status = STATUS_OUTSIDE;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Random command with its fields aimed at a canvas of the given size
   function automatic canvas_cmd_type random_request(int cols, int rows);
      canvas_cmd_type c;
      int             pick;
      c.cx   = 19'($urandom);
      c.cy   = 19'($urandom);
      c.rad  = 19'($urandom);
      c.kind = 8'($urandom);
      c.ink  = 8'($urandom);
      c.col  = 8'($urandom);
      c.row  = 8'($urandom);
      pick   = $urandom_range(0, 99);
      if (pick < 12) begin
         c.cmd = CMD_CLEAR;
      end else if (pick < 57) begin
         c.cmd = CMD_DRAW;
         // keep most centres near the canvas, a few anywhere
         if ($urandom_range(0, 9) != 0) begin
            c.cx = 19'(int'($urandom_range(0, (cols + 8) * ONE)) - 4 * ONE);
            c.cy = 19'(int'($urandom_range(0, (rows + 8) * ONE)) - 4 * ONE);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70)
            c.rad = 19'($urandom_range(1, 10 * ONE));
         else if (pick < 80)
            c.rad = 19'($urandom_range(1, ONE - 1));
         else if (pick < 90)
            c.rad = 19'(-int'($urandom_range(0, 2 * ONE)));
         pick = $urandom_range(0, 99);
         if (pick < 45)
            c.kind = KIND_FILLED;
         else if (pick < 90)
            c.kind = KIND_OUTLINE;
      end else if (pick < 94) begin
         c.cmd = CMD_READ;
         if ($urandom_range(0, 6) != 0) begin
            c.col = 8'($urandom_range(0, (cols > 255) ? 255 : cols));
            c.row = 8'($urandom_range(0, (rows > 255) ? 255 : rows));
         end
      end else begin
         c.cmd = CMD_NONE;
      end
      return c;
   endfunction

   function automatic void plan_item(logic [1:0] cmd, int cx, int cy, int rad, int kind,
                                     int ink, int col, int row, int pixel, int status);
      plan_row_type p;
      p.csr      = 1'b0;
      p.csr_idx  = REG_WIDTH;
      p.csr_val  = '0;
      p.req.cmd  = cmd;
      p.req.cx   = 19'(cx);
      p.req.cy   = 19'(cy);
      p.req.rad  = 19'(rad);
      p.req.kind = 8'(kind);
      p.req.ink  = 8'(ink);
      p.req.col  = 8'(col);
      p.req.row  = 8'(row);
      p.pixel    = pixel;
      p.status   = status;
      plan_q.push_back(p);
   endfunction

   function automatic void plan_csr(logic [1:0] idx, int val);
      plan_row_type p;
      p         = '{default: 0};
      p.csr     = 1'b1;
      p.csr_idx = idx;
      p.csr_val = 9'(val);
      plan_q.push_back(p);
   endfunction

   // Present one command, hold it until the transfer, then log its reply
   task automatic issue(canvas_cmd_type c, bit typed, pixel_reply_type want);
      pixel_reply_type res;
      csr_write_en <= 1'b0;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      req_tdata  <= {{(REQ_DATA_W - 89){1'b0}}, c.row, c.col, c.ink, c.kind,
                     c.rad, c.cy, c.cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = canvas_reply(c);
      if (typed) res = want;
      expected_q.push_back(res);
      case (c.cmd)
         CMD_CLEAR: n_clear++;
         CMD_DRAW:  begin
            n_draw++;
            if (res.status != STATUS_OK) n_rejected++;
         end
         CMD_READ:  begin
            n_read++;
            if (res.status == STATUS_OUTSIDE) n_outside++;
         end
         default:   n_none++;
      endcase
   endtask

   // Drop valid and wait for every outstanding reply
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [8:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         REG_WIDTH:      width_reg  = val;
         REG_HEIGHT:     height_reg = val;
         REG_BACKGROUND: bg_reg     = val[7:0];
         default: ;
      endcase
      n_reg_writes++;
      @(posedge clock);
   endtask

   // Result side: random stall bursts on rsp_tready
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= int'($urandom_range(0, 5));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result pixel %02h status %0d", $time,
                     rsp_tdata[7:0], rsp_tdata[9:8]);
            errors++;
         end else begin
            got_reply = expected_q.pop_front();
            n_checked++;
            if (rsp_tdata[7:0] !== got_reply.pixel) begin
               $display("%0t: pixel mismatch, expected %02h actual %02h", $time,
                        got_reply.pixel, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[9:8] !== got_reply.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d", $time,
                        got_reply.status, rsp_tdata[9:8]);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                  quiet_cycles, expected_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int              wv, hv, cols, rows;
      pixel_reply_type want;
      pixel_reply_type no_reply;
      no_reply = '{8'h00, STATUS_OK};

      // full-size clear first, so every pixel is written before any read
      plan_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 8'd32, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 255, 255, 8'd32, STATUS_OK);
      plan_item(CMD_DRAW, 128 * ONE, 128 * ONE, 10 * ONE + 128, KIND_FILLED, 8'h23,
                0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 128, 128, 8'h23, STATUS_OK);
      plan_item(CMD_DRAW, 100 * ONE + 128, 60 * ONE + 64, 20 * ONE, KIND_OUTLINE, 8'h2B,
                0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 120, 60, FROM_MODEL, FROM_MODEL);
      // rejected draws: radius checked before kind
      plan_item(CMD_DRAW, 0, 0, 0, KIND_FILLED, 8'h41, 0, 0, 8'h00, STATUS_BAD_RADIUS);
      plan_item(CMD_DRAW, -262144, 262143, -262144, 8'h78, 8'h00, 0, 0,
                8'h00, STATUS_BAD_RADIUS);
      plan_item(CMD_DRAW, 262143, -262144, 262143, 8'h00, 8'h00, 0, 0,
                8'h00, STATUS_BAD_KIND);
      plan_item(CMD_DRAW, 0, 0, 1, 8'hFF, 8'hFF, 0, 0, 8'h00, STATUS_BAD_KIND);
      plan_item(CMD_NONE, -1, -1, -1, 255, 255, 255, 255, 8'h00, STATUS_OK);
      // sizes above the maximum act as the maximum
      plan_csr(REG_WIDTH, 511);
      plan_csr(REG_HEIGHT, 300);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 255, 255, FROM_MODEL, FROM_MODEL);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 255, 0, FROM_MODEL, FROM_MODEL);
      // empty canvas
      plan_csr(REG_WIDTH, 0);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, STATUS_OUTSIDE);
      plan_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_DRAW, 0, 0, 5 * ONE, KIND_FILLED, 8'h21, 0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, STATUS_OUTSIDE);
      // small canvas, background byte masked, unused index ignored
      plan_csr(REG_WIDTH, 20);
      plan_csr(REG_HEIGHT, 12);
      plan_csr(REG_BACKGROUND, 9'h1FF);
      plan_csr(REG_UNUSED, 5);
      plan_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 19, 11, 8'hFF, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 20, 0, 8'h00, STATUS_OUTSIDE);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 0, 12, 8'h00, STATUS_OUTSIDE);
      // radius under one pixel: every covered pixel is on the rim
      plan_item(CMD_DRAW, 5 * ONE, 5 * ONE, 128, KIND_OUTLINE, 8'h6F, 0, 0,
                8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 5, 5, 8'h6F, STATUS_OK);
      plan_item(CMD_DRAW, 10 * ONE + 192, 6 * ONE + 128, 4 * ONE + 64, KIND_FILLED, 8'h2A,
                0, 0, 8'h00, STATUS_OK);
      plan_item(CMD_READ, 0, 0, 0, 0, 0, 10, 6, FROM_MODEL, FROM_MODEL);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (plan_q[i]) begin
         if (plan_q[i].csr) begin
            settle();
            write_reg(plan_q[i].csr_idx, plan_q[i].csr_val);
         end else begin
            want.pixel  = 8'(plan_q[i].pixel);
            want.status = 2'(plan_q[i].status);
            issue(plan_q[i].req, plan_q[i].pixel != FROM_MODEL, want);
         end
      end

      // random phases; the last one runs without idling
      for (int p = 0; p < 7; p++) begin
         calm     = (p == 6);
         idle_pct = calm ? 0 : 15 * $urandom_range(0, 3);
         case (p)
            0:       begin wv = 1;                      hv = 1;                      end
            5:       begin wv = $urandom_range(257, 511); hv = $urandom_range(1, 3);   end
            6:       begin wv = $urandom_range(1, 3);   hv = $urandom_range(257, 511); end
            default: begin wv = $urandom_range(2, 24);  hv = $urandom_range(2, 24);    end
         endcase
         settle();
         write_reg(REG_WIDTH, 9'(wv));
         write_reg(REG_HEIGHT, 9'(hv));
         write_reg(REG_BACKGROUND, 9'($urandom_range(0, 511)));
         if ($urandom_range(0, 1) != 0) write_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
         cols = clamp_size(width_reg);
         rows = clamp_size(height_reg);
         repeat ($urandom_range(8, 12)) issue(random_request(cols, rows), 1'b0, no_reply);
      end

      settle();
      csr_write_en <= 1'b0;
      repeat (16) @(posedge clock);

      $display("Covered %0d clears, %0d draws (%0d rejected), %0d reads (%0d outside),",
               n_clear, n_draw, n_rejected, n_read, n_outside);
      $display("%0d no-op commands, %0d register writes, %0d results checked",
               n_none, n_reg_writes, n_checked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
